>>> design/rtso_pkg.sv
// Shared types, state codes and the tile ordering function of the tile subdivider.
package rtso_pkg;

  localparam int unsigned COUNT_W = 3;

  typedef struct packed {
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [14:0]        rect_width;
    logic [14:0]        rect_height;
    logic [2:0]         split_count;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] tile_x;
    logic signed [15:0] tile_y;
    logic [14:0]        tile_width;
    logic [14:0]        tile_height;
    logic               last_tile;
  } out_word_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
  } tile_t;

  typedef struct packed {
    logic prim_vert;
    logic prim_desc;
    logic sec_desc;
  } order_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_WRITE,
    ST_READ,
    ST_FILL
  } state_t;

  // True when tile a strictly precedes tile b in the scroll order.
  function automatic logic goes_before(tile_t a, tile_t b, order_mode_t m);
    logic signed [15:0] pa;
    logic signed [15:0] pb;
    logic signed [15:0] sa;
    logic signed [15:0] sb;
    logic               res;
    pa = m.prim_vert ? $signed(a.y) : $signed(a.x);
    pb = m.prim_vert ? $signed(b.y) : $signed(b.x);
    sa = m.prim_vert ? $signed(a.x) : $signed(a.y);
    sb = m.prim_vert ? $signed(b.x) : $signed(b.y);
    if (pa != pb) begin
      res = m.prim_desc ? (pa > pb) : (pa < pb);
    end else if (sa != sb) begin
      res = m.sec_desc ? (sa > sb) : (sa < sb);
    end else begin
      res = 1'b0;
    end
    return res;
  endfunction

endpackage

>>> design/rtso_ram.sv
// Generic single-write, single-read memory with a registered read port.
module rtso_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/rtso_tilegen.sv
// Works out one tile of the split tree directly from its index in split order.
module rtso_tilegen #(
  parameter int unsigned MAX_SPLITS = 4,
  parameter int unsigned IDXW       = (MAX_SPLITS > 0) ? MAX_SPLITS : 1
) (
  input  rtso_pkg::tile_t                     rect,
  input  logic [rtso_pkg::COUNT_W-1:0]        count,
  input  logic [IDXW-1:0]                     idx,
  output rtso_pkg::tile_t                     tile
);
  import rtso_pkg::*;

  // The index bits, most significant first, pick the lower or upper half at
  // each level; odd levels halve the height and even levels the width.
  always_comb begin
    tile_t               cur;
    logic [COUNT_W-1:0]  sh;
    logic [IDXW-1:0]     sel;
    logic [15:0]         half;
    cur  = rect;
    half = '0;
    for (int s = 1; s <= int'(MAX_SPLITS); s++) begin
      sh   = count - COUNT_W'(s);
      sel  = idx >> sh;
      if (COUNT_W'(s) <= count) begin
        if ((s % 2) == 0) begin
          half = ({1'b0, cur.w} + 16'd1) >> 1;
          if (sel[0]) begin
            cur.x = cur.x + half;
            cur.w = cur.w >> 1;
          end else begin
            cur.w = half[14:0];
          end
        end else begin
          half = ({1'b0, cur.h} + 16'd1) >> 1;
          if (sel[0]) begin
            cur.y = cur.y + half;
            cur.h = cur.h >> 1;
          end else begin
            cur.h = half[14:0];
          end
        end
      end
    end
    tile = cur;
  end

endmodule

>>> design/rect_tile_subdivide_ordered.sv
// Ranking: with n = 2^min(split_count, MAX_SPLITS) tiles, each tile in turn is loaded,
// scanned against every tile and written to the tile RAM at its rank (LOAD, SCAN, WRITE).
// Emission then reads the RAM back in address order, a READ and a FILL state per word;
// a READ waits while the output slot is still full.
// A new rectangle is taken while the final word still waits at the output.
// Reset (synchronous, active low) returns the controller to idle with no word pending.
module rect_tile_subdivide_ordered #(
  parameter int unsigned MAX_SPLITS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rtso_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rtso_pkg::out_word_t out_data
);
  import rtso_pkg::*;

  localparam int unsigned IDXW  = (MAX_SPLITS > 0) ? MAX_SPLITS : 1;
  localparam int unsigned DEPTH = 1 << MAX_SPLITS;
  localparam int unsigned TW    = $bits(tile_t);

  state_t                  state_r, state_nxt;
  tile_t                   job_r, job_nxt;
  logic [COUNT_W-1:0]      cnt_r, cnt_nxt;
  order_mode_t             mode_r, mode_nxt;
  logic [IDXW:0]           n_r, n_nxt;
  logic [IDXW:0]           i_r, i_nxt;
  logic [IDXW:0]           j_r, j_nxt;
  logic [IDXW:0]           rank_r, rank_nxt;
  logic [IDXW:0]           e_r, e_nxt;
  tile_t                   key_r, key_nxt;
  tile_t                   cand_r, cand_nxt;
  logic [IDXW:0]           cand_idx_r, cand_idx_nxt;
  logic                    cand_v_r, cand_v_nxt;
  out_word_t               out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  tile_t                   gen_key;
  tile_t                   gen_cand;
  logic                    ram_we;
  logic [TW-1:0]           ram_rdata;
  tile_t                   rd_tile;
  logic                    hit;
  logic [COUNT_W-1:0]      cnt_sat;
  logic [16:0]             dx_ext, dy_ext, adx, ady;
  logic                    dx_pos, dy_pos, vert;

  rtso_tilegen #(.MAX_SPLITS(MAX_SPLITS)) u_gen_key (
    .rect  (job_r),
    .count (cnt_r),
    .idx   (i_r[IDXW-1:0]),
    .tile  (gen_key)
  );

  rtso_tilegen #(.MAX_SPLITS(MAX_SPLITS)) u_gen_cand (
    .rect  (job_r),
    .count (cnt_r),
    .idx   (j_r[IDXW-1:0]),
    .tile  (gen_cand)
  );

  // Sorted tiles land in the RAM at their rank and are read back in address order.
  rtso_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_tile_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rank_r[IDXW-1:0]),
    .wdata (key_r),
    .raddr (e_r[IDXW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_tile = tile_t'(ram_rdata);

  // A tile ranks behind every tile that precedes it, and behind an equal
  // tile that comes earlier in split order.
  assign hit = goes_before(cand_r, key_r, mode_r) ||
               ((cand_r.x == key_r.x) && (cand_r.y == key_r.y) && (cand_idx_r < i_r));

  assign cnt_sat = (in_data.split_count > COUNT_W'(MAX_SPLITS)) ?
                   COUNT_W'(MAX_SPLITS) : in_data.split_count;
  assign dx_ext  = {in_data.delta_x[15], in_data.delta_x};
  assign dy_ext  = {in_data.delta_y[15], in_data.delta_y};
  assign adx     = dx_ext[16] ? (17'd0 - dx_ext) : dx_ext;
  assign ady     = dy_ext[16] ? (17'd0 - dy_ext) : dy_ext;
  assign dx_pos  = !in_data.delta_x[15] && (in_data.delta_x != 16'sd0);
  assign dy_pos  = !in_data.delta_y[15] && (in_data.delta_y != 16'sd0);
  assign vert    = adx < ady;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cand_v_r    <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      e_r         <= '0;
      n_r         <= '0;
      rank_r      <= '0;
      cnt_r       <= '0;
      mode_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cand_v_r    <= cand_v_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      e_r         <= e_nxt;
      n_r         <= n_nxt;
      rank_r      <= rank_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    key_r      <= key_nxt;
    cand_r     <= cand_nxt;
    cand_idx_r <= cand_idx_nxt;
    out_r      <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rank_nxt      = rank_r;
    e_nxt         = e_r;
    key_nxt       = key_r;
    cand_nxt      = cand_r;
    cand_idx_nxt  = cand_idx_r;
    cand_v_nxt    = cand_v_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    ram_we        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          job_nxt.x          = in_data.rect_x;
          job_nxt.y          = in_data.rect_y;
          job_nxt.w          = in_data.rect_width;
          job_nxt.h          = in_data.rect_height;
          cnt_nxt            = cnt_sat;
          mode_nxt.prim_vert = vert;
          mode_nxt.prim_desc = vert ? dy_pos : dx_pos;
          mode_nxt.sec_desc  = vert ? dx_pos : dy_pos;
          n_nxt              = (IDXW + 1)'(1) << cnt_sat;
          i_nxt              = '0;
          state_nxt          = ST_LOAD;
        end
      end
      ST_LOAD: begin
        key_nxt    = gen_key;
        j_nxt      = '0;
        rank_nxt   = '0;
        cand_v_nxt = 1'b0;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        if (cand_v_r && hit) begin
          rank_nxt = rank_r + (IDXW + 1)'(1);
        end
        if (j_r != n_r) begin
          cand_nxt     = gen_cand;
          cand_idx_nxt = j_r;
          cand_v_nxt   = 1'b1;
          j_nxt        = j_r + (IDXW + 1)'(1);
        end else begin
          cand_v_nxt = 1'b0;
          state_nxt  = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_we = 1'b1;
        i_nxt  = i_r + (IDXW + 1)'(1);
        if (i_r + (IDXW + 1)'(1) == n_r) begin
          e_nxt     = '0;
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_READ: begin
        // The RAM read is under way; move on only once the output slot is free.
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        out_nxt.tile_x      = rd_tile.x;
        out_nxt.tile_y      = rd_tile.y;
        out_nxt.tile_width  = rd_tile.w;
        out_nxt.tile_height = rd_tile.h;
        out_nxt.last_tile   = (e_r + (IDXW + 1)'(1) == n_r);
        out_valid_nxt       = 1'b1;
        e_nxt               = e_r + (IDXW + 1)'(1);
        if (e_r + (IDXW + 1)'(1) == n_r) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the ordered rectangle tile subdivider.
`timescale 1ns / 1ps

module tb;
  import rtso_pkg::*;

  localparam int unsigned MAX_SPLITS   = 4;
  localparam int          TILE_CAP     = 1 << MAX_SPLITS;
  localparam int          RANDOM_RECTS = 358;
  localparam int          IDLE_PERCENT = 37;
  localparam int          STALL_CYCLES = 600;
  localparam int          DRAIN_CYCLES = 400;
  localparam int          REPORT_LIMIT = 10;
  // A sixteen-tile rectangle is ranked in full before its first word, and the long output
  // stall comes on top of that; the limit is several times both together.
  localparam int          QUIET_LIMIT  = 4000;

  typedef struct {
    in_word_t  rect;
    bit        typed;
    out_word_t tile;
  } rect_job_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  logic      steady;
  logic      stall_req;

  out_word_t tiles_due [$];
  rect_job_t jobs [$];
  bit        order_seen [8];
  int        n_errors;
  int        n_tiles;
  int        n_rects;
  int        n_directed;

  rect_tile_subdivide_ordered #(.MAX_SPLITS(MAX_SPLITS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic in_word_t rect(int x, int y, int w, int h, int c, int dx, int dy);
    in_word_t r;
    r.rect_x      = 16'(x);
    r.rect_y      = 16'(y);
    r.rect_width  = 15'(w);
    r.rect_height = 15'(h);
    r.split_count = 3'(c);
    r.delta_x     = 16'(dx);
    r.delta_y     = 16'(dy);
    return r;
  endfunction

  function automatic out_word_t tile(int x, int y, int w, int h, bit last);
    out_word_t t;
    t.tile_x      = 16'(x);
    t.tile_y      = 16'(y);
    t.tile_width  = 15'(w);
    t.tile_height = 15'(h);
    t.last_tile   = last;
    return t;
  endfunction

  task automatic add_row(in_word_t r, bit typed, out_word_t t);
    rect_job_t job;
    job.rect  = r;
    job.typed = typed;
    job.tile  = t;
    jobs.push_back(job);
  endtask

  // Descending order is handled by negating the keys, so one ascending compare serves.
  function automatic bit tile_precedes(tile_t a, tile_t b, logic vert, logic p_desc,
                                       logic s_desc);
    int ax, ay, bx, by, pa, pb, sa, sb;
    ax = int'($signed(a.x));
    ay = int'($signed(a.y));
    bx = int'($signed(b.x));
    by = int'($signed(b.y));
    pa = vert ? ay : ax;
    pb = vert ? by : bx;
    sa = vert ? ax : ay;
    sb = vert ? bx : by;
    if (p_desc) begin
      pa = -pa;
      pb = -pb;
    end
    if (s_desc) begin
      sa = -sa;
      sb = -sb;
    end
    return (pa < pb) || (pa == pb && sa < sb);
  endfunction

  function automatic void predict_tiles(in_word_t r);
    tile_t     parts [TILE_CAP];
    tile_t     halves [TILE_CAP];
    tile_t     t;
    tile_t     key;
    out_word_t tw;
    int        n, splits, s, i, j, c, dx, dy;
    logic      vert, p_desc, s_desc;
    n          = 1;
    parts[0].x = r.rect_x;
    parts[0].y = r.rect_y;
    parts[0].w = r.rect_width;
    parts[0].h = r.rect_height;
    splits     = (r.split_count > MAX_SPLITS) ? MAX_SPLITS : int'(r.split_count);
    for (s = 1; s <= splits; s++) begin
      for (i = 0; i < n; i++) begin
        t = parts[i];
        halves[2*i]   = t;
        halves[2*i+1] = t;
        if (s % 2 == 0) begin
          c                 = (int'(t.w) + 1) >> 1;
          halves[2*i].w     = 15'(c);
          halves[2*i+1].w   = t.w >> 1;
          halves[2*i+1].x   = t.x + 16'(c);
        end else begin
          c                 = (int'(t.h) + 1) >> 1;
          halves[2*i].h     = 15'(c);
          halves[2*i+1].h   = t.h >> 1;
          halves[2*i+1].y   = t.y + 16'(c);
        end
      end
      n = n * 2;
      for (i = 0; i < n; i++) parts[i] = halves[i];
    end

    dx     = int'(r.delta_x);
    dy     = int'(r.delta_y);
    vert   = (dx < 0 ? -dx : dx) < (dy < 0 ? -dy : dy);
    p_desc = vert ? (dy > 0) : (dx > 0);
    s_desc = vert ? (dx > 0) : (dy > 0);
    order_seen[{s_desc, p_desc, vert}] = 1'b1;

    // Insertion sort moves a tile only past strictly later ones, so ties keep split order.
    for (i = 1; i < n; i++) begin
      key = parts[i];
      j   = i;
      while (j > 0 && tile_precedes(key, parts[j-1], vert, p_desc, s_desc)) begin
        parts[j] = parts[j-1];
        j--;
      end
      parts[j] = key;
    end

    for (i = 0; i < n; i++) begin
      tw.tile_x      = parts[i].x;
      tw.tile_y      = parts[i].y;
      tw.tile_width  = parts[i].w;
      tw.tile_height = parts[i].h;
      tw.last_tile   = (i == n - 1);
      tiles_due.push_back(tw);
    end
  endfunction

  function automatic logic [15:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom);
    if (r < 80) return 16'(32767 - $urandom_range(40));
    return 16'(-32768 + $urandom_range(40));
  endfunction

  function automatic logic [14:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 35) return 15'($urandom_range(32767));
    if (r < 70) return 15'($urandom_range(20));
    return 15'($urandom_range(2000));
  endfunction

  function automatic logic [15:0] pick_delta();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 16'($urandom);
    if (r < 75) return 16'($urandom_range(32) - 16);
    if (r < 85) return 16'd0;
    case ($urandom_range(3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h8001;
      default: return 16'hffff;
    endcase
  endfunction

  // Mostly small split counts keep the run short; a few saturate at the largest.
  function automatic in_word_t random_rect();
    in_word_t r;
    int       pick;
    r.rect_x      = pick_coord();
    r.rect_y      = pick_coord();
    r.rect_width  = pick_size();
    r.rect_height = pick_size();
    pick          = $urandom_range(99);
    if (pick < 25) r.split_count = 3'd0;
    else if (pick < 50) r.split_count = 3'd1;
    else if (pick < 72) r.split_count = 3'd2;
    else if (pick < 88) r.split_count = 3'd3;
    else r.split_count = 3'($urandom_range(7, 4));
    r.delta_x = pick_delta();
    if ($urandom_range(99) < 15) begin
      r.delta_y = $urandom_range(1) ? r.delta_x : -r.delta_x;
    end else begin
      r.delta_y = pick_delta();
    end
    return r;
  endfunction

  task automatic check_tile(out_word_t got);
    out_word_t want;
    n_tiles++;
    if (tiles_due.size() == 0) begin
      n_errors++;
      if (n_errors <= REPORT_LIMIT) begin
        $display("ERROR: tile word with nothing expected: x=%0d y=%0d w=%0d h=%0d last=%0b",
                 got.tile_x, got.tile_y, got.tile_width, got.tile_height, got.last_tile);
      end
    end else begin
      want = tiles_due.pop_front();
      if (got.tile_x !== want.tile_x || got.tile_y !== want.tile_y ||
          got.tile_width !== want.tile_width || got.tile_height !== want.tile_height ||
          got.last_tile !== want.last_tile) begin
        n_errors++;
        if (n_errors <= REPORT_LIMIT) begin
          $display("ERROR: tile %0d expected x=%0d y=%0d w=%0d h=%0d last=%0b", n_tiles,
                   want.tile_x, want.tile_y, want.tile_width, want.tile_height,
                   want.last_tile);
          $display("       got              x=%0d y=%0d w=%0d h=%0d last=%0b",
                   got.tile_x, got.tile_y, got.tile_width, got.tile_height, got.last_tile);
        end
      end
    end
  endtask

  // Result side: checks each word and stalls at random, once for a long stretch.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_tile(out_data);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_req && !held) begin
        held      = 1'b1;
        hold_left = STALL_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no word moved on either side for %0d cycles", QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rect_job_t job;
    int        i;
    int        orders;
    n_errors = 0;
    n_tiles  = 0;
    n_rects  = 0;
    orders   = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    steady    <= 1'b0;
    stall_req <= 1'b0;

    // Single-tile rows carry their expected word; the rest go through the predictor.
    add_row(rect(0, 0, 0, 0, 0, 0, 0), 1'b1, tile(0, 0, 0, 0, 1'b1));
    add_row(rect(-32768, -32768, 32767, 32767, 0, -32768, -32768), 1'b1,
            tile(-32768, -32768, 32767, 32767, 1'b1));
    add_row(rect(32767, 32767, 0, 32767, 0, 32767, -1), 1'b1,
            tile(32767, 32767, 0, 32767, 1'b1));
    add_row(rect(-1, 0, 32767, 0, 0, 0, 32767), 1'b1, tile(-1, 0, 32767, 0, 1'b1));
    add_row(rect(100, 200, 40, 30, 1, -3, 1), 1'b0, '0);
    add_row(rect(100, 200, 40, 30, 2, -3, 1), 1'b0, '0);
    add_row(rect(-50, -60, 33, 17, 3, 9, -2), 1'b0, '0);
    add_row(rect(10, -10, 1000, 999, 4, 1, -7), 1'b0, '0);
    add_row(rect(0, 0, 7, 9, 4, -2, 300), 1'b0, '0);
    add_row(rect(5, 5, 64, 64, 4, -8, 8), 1'b0, '0);
    add_row(rect(5, 5, 64, 64, 4, 8, -8), 1'b0, '0);
    add_row(rect(0, 0, 16, 16, 4, 0, 0), 1'b0, '0);
    add_row(rect(-1000, 1000, 500, 300, 3, -32768, 32767), 1'b0, '0);
    add_row(rect(-1000, 1000, 500, 300, 3, 32767, -32768), 1'b0, '0);
    add_row(rect(0, 0, 32767, 32767, 5, 2, 9), 1'b0, '0);
    add_row(rect(-32768, 32767, 32767, 32767, 6, 3, 4), 1'b0, '0);
    add_row(rect(12345, -12345, 321, 123, 7, -4, -4), 1'b0, '0);
    add_row(rect(32760, 32700, 100, 200, 2, 1, 0), 1'b0, '0);
    add_row(rect(32767, 32767, 32767, 32767, 4, -1, -1), 1'b0, '0);
    add_row(rect(3, 4, 1, 1, 4, 0, 0), 1'b0, '0);
    add_row(rect(3, 4, 0, 0, 3, 5, 5), 1'b0, '0);
    add_row(rect(-7, -7, 2, 3, 4, -6, -6), 1'b0, '0);
    n_directed = jobs.size();
    for (i = 0; i < RANDOM_RECTS; i++) begin
      job.rect  = random_rect();
      job.typed = 1'b0;
      job.tile  = '0;
      jobs.push_back(job);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < jobs.size(); i++) begin
      if (i == 100) stall_req <= 1'b1;
      steady   <= (i >= 150 && i < 215);
      in_valid <= 1'b1;
      in_data  <= jobs[i].rect;
      do @(posedge clk); while (!in_ready);
      n_rects++;
      if (jobs[i].typed) tiles_due.push_back(jobs[i].tile);
      else predict_tiles(jobs[i].rect);
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
      end
    end
    in_valid <= 1'b0;

    while (tiles_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    for (i = 0; i < 8; i++) orders += order_seen[i];
    $display("Sent %0d rectangles (%0d from the directed table), checked %0d tile words, %0d errors.",
             n_rects, n_directed, n_tiles, n_errors);
    $display("Covered %0d of 8 scroll orders and a %0d-cycle output stall with the input backed up.",
             orders, STALL_CYCLES);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/rtso_pkg.sv
design/rtso_ram.sv
design/rtso_tilegen.sv
design/rect_tile_subdivide_ordered.sv
tb/tb.sv
